>>> rtl/chtfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chtfl_pkg
// Operation and status codes for the chained hash table.
// ----------------------------------------------------------------------------
package chtfl_pkg;

   typedef logic [1:0] kind_type;
   typedef logic [1:0] status_type;

   localparam kind_type KIND_SEARCH = 2'd0;
   localparam kind_type KIND_INSERT = 2'd1;
   localparam kind_type KIND_REMOVE = 2'd2;

   localparam status_type ST_DONE      = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_DUPLICATE = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

endpackage
`default_nettype wire

>>> rtl/chained_hash_table_free_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_free_list
// Keyed record table: buckets by |key| mod BUCKETS, singly linked chains in
// record memory, slots recycled through a free-list stack.
//
//   channel  ports                                 handshake
//   request  req_kind req_key req_stock_in ...     start & !busy
//   response rsp_status rsp_stock_out rsp_price..  rsp_valid, one cycle
//
// An item steps through HEAD, then RD and CHK for each chain entry checked,
// where a miss also checks the chain end; an insert that misses and a remove
// that hits add FREE and ACT for the free-list read and the write-back. After
// reset a clearing pass writes every bucket head with busy high. Results cannot
// be stalled; rsp_valid is high in the first cycle with busy low again.
// ----------------------------------------------------------------------------
module chained_hash_table_free_list #(
   parameter int BUCKETS = 256,
   parameter int RECORDS = 1024
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire chtfl_pkg::kind_type req_kind,
   input  wire  signed [31:0]       req_key,
   input  wire  signed [31:0]       req_stock_in,
   input  wire         [31:0]       req_price_in,
   output logic                    rsp_valid,
   output chtfl_pkg::status_type   rsp_status,
   output logic signed [31:0]      rsp_stock_out,
   output logic        [31:0]      rsp_price_out
);
   import chtfl_pkg::*;

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
   localparam int LW = SW + 1;
   localparam int UW = $clog2(RECORDS + 1);
   localparam int NW = $clog2(RECORDS + 1);
   localparam logic [LW-1:0] NIL = '1;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HEAD  = 3'd2;
   localparam logic [2:0] S_RD    = 3'd3;
   localparam logic [2:0] S_CHK   = 3'd4;
   localparam logic [2:0] S_FREE  = 3'd5;
   localparam logic [2:0] S_ACT   = 3'd6;
   localparam logic [2:0] S_RSP   = 3'd7;

   logic [LW-1:0] head_mem [BUCKETS];
   logic [31:0]   key_mem [RECORDS];
   logic [31:0]   stk_mem [RECORDS];
   logic [31:0]   prc_mem [RECORDS];
   logic [LW-1:0] lnk_mem [RECORDS];

   logic [2:0]    state_ff;
   logic [BW-1:0] clr_ff;
   logic [LW-1:0] free_ff;
   logic [UW-1:0] used_ff;
   logic [1:0]    kind_ff;
   logic [31:0]   key_ff, stk_ff, prc_ff;
   logic [BW-1:0] bkt_ff;
   logic [LW-1:0] cur_ff, prev_ff, head_ff;
   logic [NW-1:0] cnt_ff;
   logic [LW-1:0] head_q, lnk_q;
   logic [31:0]   key_q, stk_q, prc_q;
   logic [1:0]    st_ff;
   logic [31:0]   so_ff, po_ff;
   logic          found_ff;

   logic [31:0]   mag_in;
   logic [BW-1:0] bkt_in;
   logic          head_we, lnk_we, rec_we;
   logic [BW-1:0] head_wa;
   logic [LW-1:0] head_wd, lnk_wd;
   logic [SW-1:0] lnk_wa, rd_a;

   assign mag_in = req_key[31] ? (32'd0 - req_key) : req_key;
   assign bkt_in = (BUCKETS > 1) ? BW'(mag_in % BUCKETS) : '0;
   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) head_q <= head_mem[bkt_in];
      else                    head_q <= head_mem[bkt_ff];
      if (head_we) head_mem[head_wa] <= head_wd;
   end

   always_comb begin
      rd_a = (state_ff == S_ACT || state_ff == S_FREE) ? free_ff[SW-1:0] : cur_ff[SW-1:0];
   end

   always_ff @(posedge clock) begin
      key_q <= key_mem[rd_a];
      stk_q <= stk_mem[rd_a];
      prc_q <= prc_mem[rd_a];
      lnk_q <= lnk_mem[rd_a];
      if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
      if (rec_we) begin
         key_mem[lnk_wa] <= key_ff;
         stk_mem[lnk_wa] <= stk_ff;
         prc_mem[lnk_wa] <= prc_ff;
      end
   end

   logic          valid_cur, hit, alloc_free, alloc_new;
   assign valid_cur  = (cur_ff < LW'(RECORDS)) && (cnt_ff < NW'(RECORDS));
   assign hit        = valid_cur && (key_q == key_ff);
   assign alloc_free = free_ff < LW'(RECORDS);
   assign alloc_new  = !alloc_free && (used_ff < UW'(RECORDS));

   always_comb begin
      head_we = 1'b0; head_wa = bkt_ff; head_wd = NIL;
      lnk_we = 1'b0; rec_we = 1'b0; lnk_wa = cur_ff[SW-1:0]; lnk_wd = NIL;
      if (state_ff == S_CLEAR) begin
         head_we = 1'b1; head_wa = clr_ff;
      end else if (state_ff == S_ACT && found_ff && kind_ff == KIND_REMOVE) begin
         lnk_we = 1'b1; lnk_wa = cur_ff[SW-1:0]; lnk_wd = free_ff;
      end else if (state_ff == S_ACT && found_ff && kind_ff == KIND_INSERT) begin
         head_we = 1'b1; head_wd = cur_ff;
         lnk_we = 1'b1; rec_we = 1'b1; lnk_wa = cur_ff[SW-1:0]; lnk_wd = head_ff;
      end else if (state_ff == S_FREE && kind_ff == KIND_REMOVE) begin
         if (prev_ff == NIL) begin
            head_we = 1'b1; head_wd = lnk_q;
         end else begin
            lnk_we = 1'b1; lnk_wa = prev_ff[SW-1:0]; lnk_wd = lnk_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid <= !reset && (state_ff == S_RSP);
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         free_ff  <= NIL;
         used_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BW'(BUCKETS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               kind_ff <= req_kind; key_ff <= req_key;
               stk_ff <= req_stock_in; prc_ff <= req_price_in;
               bkt_ff <= bkt_in; prev_ff <= NIL; cnt_ff <= '0;
               found_ff <= 1'b0;
               state_ff <= S_HEAD;
            end
            S_HEAD: begin
               cur_ff <= head_q; head_ff <= head_q;
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_CHK;
            S_CHK: begin
               so_ff <= (hit && kind_ff == KIND_SEARCH) ? stk_q : '0;
               po_ff <= (hit && kind_ff == KIND_SEARCH) ? prc_q : '0;
               if (hit) begin
                  unique case (kind_ff)
                     KIND_SEARCH: begin
                        st_ff <= ST_DONE; state_ff <= S_RSP;
                     end
                     KIND_INSERT: begin
                        st_ff <= ST_DUPLICATE; state_ff <= S_RSP;
                     end
                     KIND_REMOVE: begin
                        st_ff <= ST_DONE; found_ff <= 1'b1;
                        state_ff <= S_FREE;
                     end
                     default: begin
                        st_ff <= ST_NOT_FOUND; state_ff <= S_RSP;
                     end
                  endcase
               end else if (valid_cur) begin
                  prev_ff <= cur_ff; cur_ff <= lnk_q;
                  cnt_ff <= cnt_ff + 1'b1;
                  state_ff <= S_RD;
               end else if (kind_ff == KIND_INSERT) begin
                  if (alloc_free || alloc_new) begin
                     st_ff <= ST_DONE; found_ff <= 1'b1;
                     cur_ff <= alloc_free ? free_ff : LW'(used_ff);
                     if (alloc_new) used_ff <= used_ff + 1'b1;
                  end else st_ff <= ST_FULL;
                  state_ff <= S_FREE;
               end else begin
                  st_ff <= ST_NOT_FOUND; state_ff <= S_RSP;
               end
            end
            S_FREE: state_ff <= S_ACT;
            S_ACT: begin
               if (found_ff && kind_ff == KIND_REMOVE) free_ff <= cur_ff;
               else if (found_ff && cur_ff == free_ff) free_ff <= lnk_q;
               state_ff <= S_RSP;
            end
            S_RSP: begin
               rsp_status <= st_ff; rsp_stock_out <= so_ff; rsp_price_out <= po_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("accepted item did not raise busy");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   assert property (@(posedge clock) disable iff (reset) used_ff <= UW'(RECORDS))
      else $error("high-water count beyond table size");
   assert property (@(posedge clock) disable iff (reset) rsp_valid && rsp_status != ST_DONE
      |-> rsp_stock_out == '0 && rsp_price_out == '0)
      else $error("payload on failed result");

endmodule
`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chained hash table. A directed table of
// operations is run first, then random searches, inserts and removes. A
// fill phase brings the table to full and a random phase churns the free list.
// Each result is compared with a record-table model that runs in the bench.
// ----------------------------------------------------------------------------
module tb_top;
   import chtfl_pkg::*;

   localparam int BUCKETS = 256;
   localparam int RECORDS = 1024;
   localparam logic [31:0] NIL = 32'hFFFF_FFFF;
   localparam kind_type KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 20_000_000;

   typedef struct packed {
      status_type  status;
      logic [31:0] stock;
      logic [31:0] price;
   } outcome_t;

   typedef struct {
      kind_type    kind;
      logic [31:0] key;
      logic [31:0] stock;
      logic [31:0] price;
      bit          typed;
      status_type  status;
   } op_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   kind_type req_kind = KIND_SEARCH;
   logic signed [31:0] req_key = '0;
   logic signed [31:0] req_stock_in = '0;
   logic [31:0] req_price_in = '0;
   logic rsp_valid;
   status_type rsp_status;
   logic signed [31:0] rsp_stock_out;
   logic [31:0] rsp_price_out;

   chained_hash_table_free_list #(.BUCKETS(BUCKETS), .RECORDS(RECORDS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_key(req_key), .req_stock_in(req_stock_in),
      .req_price_in(req_price_in), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_stock_out(rsp_stock_out), .rsp_price_out(rsp_price_out)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [31:0] heads [BUCKETS];
   logic [31:0] free_top;
   logic [31:0] high_water;
   logic [31:0] slot_key [RECORDS];
   logic [31:0] slot_stock [RECORDS];
   logic [31:0] slot_price [RECORDS];
   logic [31:0] slot_link [RECORDS];

   outcome_t pending [$];
   logic [31:0] fill_keys [$];
   op_row_t stim_rows [$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int full_hits = 0;
   int cycles = 0;
   bit quiet = 1'b0;

   function automatic logic [31:0] bucket_of(logic [31:0] key);
      logic [31:0] mag;
      mag = key[31] ? (32'd0 - key) : key;
      return mag % BUCKETS;
   endfunction

   function automatic logic [31:0] walk(logic [31:0] b, logic [31:0] key,
                                        output logic [31:0] prev);
      logic [31:0] cur;
      logic [31:0] behind;
      cur = heads[b];
      behind = NIL;
      prev = NIL;
      for (int n = 0; n < RECORDS; n++) begin
         if (cur >= RECORDS) break;
         if (slot_key[cur] == key) begin
            prev = behind;
            return cur;
         end
         behind = cur;
         cur = slot_link[cur];
      end
      return NIL;
   endfunction

   function automatic outcome_t apply_op(kind_type kind, logic [31:0] key,
                                         logic [31:0] stock, logic [31:0] price);
      outcome_t r;
      logic [31:0] b, prev, slot, fresh;
      r = '{status: ST_NOT_FOUND, stock: '0, price: '0};
      b = bucket_of(key);
      case (kind)
         KIND_SEARCH: begin
            slot = walk(b, key, prev);
            if (slot != NIL) begin
               r.status = ST_DONE;
               r.stock = slot_stock[slot];
               r.price = slot_price[slot];
            end
         end
         KIND_INSERT: begin
            slot = walk(b, key, prev);
            if (slot != NIL) begin
               r.status = ST_DUPLICATE;
            end else begin
               fresh = NIL;
               if (free_top < RECORDS) begin
                  fresh = free_top;
                  free_top = slot_link[fresh];
               end else if (high_water < RECORDS) begin
                  fresh = high_water;
                  high_water++;
               end
               if (fresh == NIL) begin
                  r.status = ST_FULL;
               end else begin
                  slot_key[fresh] = key;
                  slot_stock[fresh] = stock;
                  slot_price[fresh] = price;
                  slot_link[fresh] = heads[b];
                  heads[b] = fresh;
                  r.status = ST_DONE;
               end
            end
         end
         KIND_REMOVE: begin
            slot = walk(b, key, prev);
            if (slot != NIL) begin
               if (prev == NIL) heads[b] = slot_link[slot];
               else slot_link[prev] = slot_link[slot];
               slot_link[slot] = free_top;
               free_top = slot;
               r.status = ST_DONE;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic issue(kind_type kind, logic [31:0] key, logic [31:0] stock,
                        logic [31:0] price, bit typed = 1'b0,
                        status_type status = ST_DONE);
      outcome_t r;
      if (!quiet && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_key <= key;
      req_stock_in <= stock;
      req_price_in <= price;
      do @(posedge clock); while (busy);
      r = apply_op(kind, key, stock, price);
      if (typed) r = '{status: status, stock: '0, price: '0};
      if (r.status == ST_FULL) full_hits++;
      pending.push_back(r);
      items_sent++;
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
   endtask

   function automatic void add_row(kind_type kind, logic [31:0] key, logic [31:0] stock,
                                   logic [31:0] price, bit typed, status_type status);
      stim_rows.push_back('{kind, key, stock, price, typed, status});
   endfunction

   function automatic logic [31:0] churn_key();
      logic [31:0] k;
      case ($urandom_range(0, 7))
         0: k = $urandom;
         7: case ($urandom_range(0, 3))
               0: k = 32'h8000_0000;
               1: k = 32'h7FFF_FFFF;
               2: k = NIL;
               default: k = '0;
            endcase
         default: begin
            k = $urandom_range(0, 40) * BUCKETS + $urandom_range(0, 3);
            if ($urandom_range(0, 1)) k = 32'd0 - k;
         end
      endcase
      return k;
   endfunction

   function automatic kind_type pick_kind();
      int p;
      p = $urandom_range(0, 99);
      if (p < 35) return KIND_INSERT;
      if (p < 65) return KIND_SEARCH;
      if (p < 95) return KIND_REMOVE;
      return KIND_UNUSED;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      outcome_t e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
         end else begin
            e = pending.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d got %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_stock_out !== e.stock) begin
               $error("stock_out expected %0d got %0d", $signed(e.stock), rsp_stock_out);
               errors++;
            end
            if (rsp_price_out !== e.price) begin
               $error("price_out expected %0d got %0d", e.price, rsp_price_out);
               errors++;
            end
         end
      end
   end

   initial begin
      logic [31:0] k;
      for (int i = 0; i < BUCKETS; i++) heads[i] = NIL;
      free_top = NIL;
      high_water = 0;

      add_row(KIND_SEARCH, 32'd0, 32'd0, 32'd0, 1, ST_NOT_FOUND);
      add_row(KIND_REMOVE, 32'd0, 32'd0, 32'd0, 1, ST_NOT_FOUND);
      add_row(KIND_INSERT, 32'd0, 32'h8000_0000, 32'd0, 1, ST_DONE);
      add_row(KIND_INSERT, 32'd0, 32'd5, 32'd5, 1, ST_DUPLICATE);
      add_row(KIND_SEARCH, 32'd0, 32'd0, 32'd0, 0, ST_DONE);
      add_row(KIND_INSERT, 32'd256, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, ST_DONE);
      add_row(KIND_INSERT, -32'sd256, 32'hFFFF_FFFF, 32'd1, 1, ST_DONE);
      add_row(KIND_INSERT, 32'h8000_0000, 32'd77, 32'd12345, 1, ST_DONE);
      add_row(KIND_INSERT, 32'h7FFF_FFFF, 32'd0, 32'hAAAA_5555, 1, ST_DONE);
      add_row(KIND_INSERT, -32'sd1, 32'h5555_AAAA, 32'd0, 1, ST_DONE);
      add_row(KIND_SEARCH, 32'h8000_0000, 32'd0, 32'd0, 0, ST_DONE);
      add_row(KIND_SEARCH, 32'h7FFF_FFFF, 32'd0, 32'd0, 0, ST_DONE);
      add_row(KIND_SEARCH, 32'd256, 32'd0, 32'd0, 0, ST_DONE);
      add_row(KIND_REMOVE, 32'd256, 32'd0, 32'd0, 1, ST_DONE);
      add_row(KIND_SEARCH, 32'd256, 32'd0, 32'd0, 1, ST_NOT_FOUND);
      add_row(KIND_REMOVE, -32'sd256, 32'd0, 32'd0, 1, ST_DONE);
      add_row(KIND_REMOVE, 32'd512, 32'd0, 32'd0, 1, ST_NOT_FOUND);
      add_row(KIND_UNUSED, 32'd0, 32'd0, 32'd0, 1, ST_NOT_FOUND);
      add_row(KIND_SEARCH, 32'd0, 32'd0, 32'd0, 0, ST_DONE);
      add_row(KIND_INSERT, 32'd768, 32'd9, 32'd9, 1, ST_DONE);
      add_row(KIND_SEARCH, 32'd768, 32'd0, 32'd0, 0, ST_DONE);
      add_row(KIND_REMOVE, 32'd0, 32'd0, 32'd0, 1, ST_DONE);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         issue(stim_rows[i].kind, stim_rows[i].key, stim_rows[i].stock,
               stim_rows[i].price, stim_rows[i].typed, stim_rows[i].status);

      repeat (600) issue(pick_kind(), churn_key(), $urandom, $urandom);

      drain();
      quiet = 1'b1;
      for (int i = 0; i < 1100; i++) begin
         k = 32'h4000_0000 + i * 37;
         if (i % 3 == 0) k = 32'd0 - k;
         fill_keys.push_back(k);
         issue(KIND_INSERT, k, $urandom, $urandom);
      end
      issue(KIND_INSERT, fill_keys[5], $urandom, $urandom);
      quiet = 1'b0;

      repeat (400) begin
         k = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
         if ($urandom_range(0, 9) == 0) k = churn_key();
         issue(pick_kind(), k, $urandom, $urandom);
      end

      drain();
      repeat (4 + 2 * RECORDS) @(posedge clock);
      $display("ran %0d items, %0d results, %0d table-full rejects, through fill and churn",
               items_sent, results_seen, full_hits);
      if (errors == 0 && pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

>>> chained_hash_table_free_list.f
rtl/chtfl_pkg.sv
rtl/chained_hash_table_free_list.sv
test/tb_top.sv
